FILE: sv/ltes_pkg.sv
// ----------------------------------------------------------------------------
// ltes_pkg
// Shared types and codes for the light tile extent search block.
// ----------------------------------------------------------------------------
`default_nettype none
package ltes_pkg;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam logic [6:0] CFG_GRID_WIDTH  = 7'd0;
    localparam logic [6:0] CFG_GRID_HEIGHT = 7'd1;

    // shared distance unit opcodes
    localparam logic [1:0] OP_CLR = 2'd0;
    localparam logic [1:0] OP_MAC = 2'd1;
    localparam logic [1:0] OP_FIN = 2'd2;
    localparam logic [1:0] OP_SQ  = 2'd3;

    // one-hot sequencer states
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_RD    = 8'b0000_0010,
        ST_WAIT  = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_SUM   = 8'b0001_0000,
        ST_SQ    = 8'b0010_0000,
        ST_CMP   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } t_state;

    // step phase within one axis search
    typedef enum logic [2:0] {
        PH_FIRST = 3'b001,
        PH_LAST  = 3'b010,
        PH_BIN   = 3'b100
    } t_phase;
endpackage
`default_nettype wire

FILE: sv/ltes_ram.sv
// ----------------------------------------------------------------------------
// ltes_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ltes_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: sv/ltes_dist_unit.sv
// ----------------------------------------------------------------------------
// ltes_dist_unit
// Shared plane distance unit: one multiply per cycle, accumulate, saturate,
// then square; sequenced by the top level through an opcode.
// ----------------------------------------------------------------------------
`default_nettype none
module ltes_dist_unit #(
    parameter int COORD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic [1:0]  i_op,      // clear acc, mul-acc, finish, square
    input  wire logic [31:0] i_coef,
    input  wire logic [31:0] i_coord,
    input  wire logic [31:0] i_offset,
    output logic signed [63:0] o_sq
);
    import ltes_pkg::*;

    localparam logic signed [65:0] LIM = 66'sd1 <<< (COORD_BITS - 1);

    logic signed [65:0] r_acc;
    logic signed [31:0] r_t;
    logic signed [31:0] w_a;
    logic signed [31:0] w_b;
    logic signed [63:0] w_prod;
    logic signed [65:0] w_t;
    logic signed [63:0] w_sq;

    // operand sign extension from the low coordinate bits
    assign w_a = 32'(signed'(i_coef[COORD_BITS-1:0]));
    assign w_b = 32'(signed'(i_coord[COORD_BITS-1:0]));
    assign w_prod = w_a * w_b;
    assign w_t = (r_acc >>> 16) + 66'(signed'(i_offset[COORD_BITS-1:0]));
    assign w_sq = r_t * r_t;

    // accumulate products, saturate the distance, square it
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_CLR: r_acc <= '0;
            OP_MAC: r_acc <= r_acc + 66'(w_prod);
            OP_FIN: begin
                if (w_t > LIM - 66'sd1) r_t <= 32'(LIM - 66'sd1);
                else if (w_t < -LIM)   r_t <= 32'(-LIM);
                else                    r_t <= 32'(w_t);
            end
            OP_SQ: o_sq <= r_t[31] ? -w_sq : w_sq;
            default: r_acc <= r_acc;
        endcase
    end
endmodule
`default_nettype wire

FILE: sv/light_tile_extent_search.sv
// ----------------------------------------------------------------------------
// light_tile_extent_search
// Tile range of a spherical light: four binary searches over delimiter
// plane tables, all plane evaluations on one shared distance unit.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  item in   i_start / o_busy       i_cmd .. i_radius_squared
//  result    o_valid (one cycle)    o_was_query, o_tile_*
//  config    i_cfg_we               i_cfg_index, i_cfg_data
//
//  A write item goes from idle straight to done. A query runs four searches;
//  each plane evaluation steps through the shared distance unit (RAM read and
//  wait, three multiplies, finish, square, compare). Reset is synchronous;
//  the result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module light_tile_extent_search #(
    parameter int MAX_TILES  = 64,
    parameter int COORD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [6:0]  i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_cmd,
    input  wire logic        i_plane_axis,
    input  wire logic [6:0]  i_plane_index,
    input  wire logic [31:0] i_coef_a,
    input  wire logic [31:0] i_coef_b,
    input  wire logic [31:0] i_coef_c,
    input  wire logic [31:0] i_coef_d,
    input  wire logic [31:0] i_centre_x,
    input  wire logic [31:0] i_centre_y,
    input  wire logic [31:0] i_centre_z,
    input  wire logic [62:0] i_radius_squared,
    output logic             o_valid,
    output logic             o_was_query,
    output logic [6:0]       o_tile_min_x,
    output logic [6:0]       o_tile_min_y,
    output logic [6:0]       o_tile_max_x,
    output logic [6:0]       o_tile_max_y
);
    import ltes_pkg::*;

    localparam int DEPTH = MAX_TILES + 1;
    localparam int AW    = $clog2(DEPTH);

    t_state      r_state, n_state;
    t_phase      r_phase;
    logic [6:0]  r_grid_w, r_grid_h;
    logic        r_cmd;
    logic [1:0]  r_search;   // bit0 axis (horiz), bit1 want_last
    logic [2:0]  r_sub;
    logic [AW-1:0] r_lo, r_hi, r_mid, r_top;
    logic [31:0] r_x, r_y, r_z;
    logic [62:0] r_rsq;
    logic [6:0]  r_res [4];

    logic          w_we_v, w_we_h, w_in_range;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [63:0]   w_xy_v, w_zo_v, w_xy_h, w_zo_h, w_xy, w_zo;
    logic [1:0]    w_op;
    logic [31:0]   w_coef, w_coord;
    logic signed [63:0] w_sq;
    logic signed [64:0] w_bound, w_s;
    logic          w_gt, w_lt;
    logic [6:0]    w_grid;
    logic [AW-1:0] w_top;
    logic          w_fin;
    logic [AW-1:0] w_res, w_nlo, w_nhi;

    // plane tables
    assign w_in_range = 32'(i_plane_index) <= MAX_TILES;
    assign w_waddr = AW'(i_plane_index);
    assign w_we_v = (r_state == ST_IDLE) && i_start && (i_cmd == CMD_WRITE)
                    && w_in_range && !i_plane_axis;
    assign w_we_h = (r_state == ST_IDLE) && i_start && (i_cmd == CMD_WRITE)
                    && w_in_range && i_plane_axis;
    assign w_raddr = r_mid;

    ltes_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_vxy (.i_clk, .i_we(w_we_v), .i_waddr(w_waddr),
        .i_wdata({i_coef_b, i_coef_a}), .i_raddr(w_raddr), .o_rdata(w_xy_v));
    ltes_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_vzo (.i_clk, .i_we(w_we_v), .i_waddr(w_waddr),
        .i_wdata({i_coef_d, i_coef_c}), .i_raddr(w_raddr), .o_rdata(w_zo_v));
    ltes_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_hxy (.i_clk, .i_we(w_we_h), .i_waddr(w_waddr),
        .i_wdata({i_coef_b, i_coef_a}), .i_raddr(w_raddr), .o_rdata(w_xy_h));
    ltes_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_hzo (.i_clk, .i_we(w_we_h), .i_waddr(w_waddr),
        .i_wdata({i_coef_d, i_coef_c}), .i_raddr(w_raddr), .o_rdata(w_zo_h));

    assign w_xy = r_search[0] ? w_xy_h : w_xy_v;
    assign w_zo = r_search[0] ? w_zo_h : w_zo_v;

    // operand select for the shared unit
    always_comb begin
        w_op = OP_CLR;
        w_coef = w_xy[31:0];
        w_coord = r_x;
        case (r_state)
            ST_MUL: begin
                w_op = OP_MAC;
                case (r_sub)
                    3'd0: begin w_coef = w_xy[31:0];  w_coord = r_x; end
                    3'd1: begin w_coef = w_xy[63:32]; w_coord = r_y; end
                    default: begin w_coef = w_zo[31:0]; w_coord = r_z; end
                endcase
            end
            ST_SUM: w_op = OP_FIN;
            ST_SQ:  w_op = OP_SQ;
            ST_CMP: w_op = OP_CLR;
            default: w_op = OP_CLR;
        endcase
    end

    ltes_dist_unit #(.COORD_BITS(COORD_BITS)) u_dist (.i_clk, .i_op(w_op), .i_coef(w_coef),
        .i_coord(w_coord), .i_offset(w_zo[63:32]), .o_sq(w_sq));

    // compare against the signed bound
    assign w_bound = r_search[1] ? -65'(r_rsq) : 65'(r_rsq);
    assign w_s  = 65'(w_sq);
    assign w_gt = w_s > w_bound;
    assign w_lt = w_s < w_bound;
    assign w_grid = r_search[0] ? r_grid_h : r_grid_w;
    assign w_top = (32'(w_grid) > MAX_TILES) ? AW'(MAX_TILES) : AW'(w_grid);

    // one search step: decide whether this axis search is finished, its result and the narrowed range
    always_comb begin
        w_fin = 1'b0;
        w_res = '0;
        w_nlo = w_gt ? r_mid : r_lo;
        w_nhi = w_gt ? r_hi : r_mid;
        case (r_phase)
            PH_FIRST: begin
                if (w_lt) w_fin = 1'b1;
            end
            PH_LAST: begin
                if (w_gt) begin
                    w_fin = 1'b1;
                    w_res = r_top;
                end else if (r_top - r_lo <= AW'(1)) begin
                    w_fin = 1'b1;
                    w_res = r_search[1] ? r_top : r_lo;
                end
            end
            PH_BIN: begin
                if (w_nhi - w_nlo <= AW'(1)) begin
                    w_fin = 1'b1;
                    w_res = r_search[1] ? w_nhi : w_nlo;
                end
            end
            default: w_fin = 1'b0;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_start) n_state = (i_cmd == CMD_QUERY) ? ST_RD : ST_DONE;
            ST_RD:   n_state = ST_WAIT;
            ST_WAIT: n_state = ST_MUL;
            ST_MUL:  if (r_sub == 3'd2) n_state = ST_SUM;
            ST_SUM:  n_state = ST_SQ;
            ST_SQ:   n_state = ST_CMP;
            ST_CMP:  n_state = (w_fin && r_search == 2'd3) ? ST_DONE : ST_RD;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer, config, search and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_grid_w <= 7'd16;
            r_grid_h <= 7'd16;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we && i_cfg_index == CFG_GRID_WIDTH)  r_grid_w <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_GRID_HEIGHT) r_grid_h <= i_cfg_data;
            r_state <= n_state;
            case (r_state)
                ST_IDLE: if (i_start) begin
                    r_cmd    <= i_cmd;
                    r_x      <= i_centre_x;
                    r_y      <= i_centre_y;
                    r_z      <= i_centre_z;
                    r_rsq    <= i_radius_squared;
                    r_search <= 2'd0;
                    r_phase  <= PH_FIRST;
                    r_mid    <= '0;
                    r_lo     <= '0;
                end
                ST_RD: r_sub <= 3'd0;
                ST_MUL: r_sub <= r_sub + 3'd1;
                ST_CMP: begin
                    // record a finished search and move on, else narrow the range
                    if (w_fin) begin
                        r_res[r_search] <= 7'(w_res);
                        r_phase <= PH_FIRST;
                        r_mid <= '0;
                        r_lo <= '0;
                        r_search <= r_search + 2'd1;
                    end else begin
                        case (r_phase)
                            PH_FIRST: begin
                                r_phase <= PH_LAST;
                                r_mid <= w_top;
                                r_top <= w_top;
                            end
                            PH_LAST: begin
                                r_phase <= PH_BIN;
                                r_hi <= r_top;
                                r_mid <= r_lo + ((r_top - r_lo) >> 1);
                            end
                            PH_BIN: begin
                                r_lo <= w_nlo;
                                r_hi <= w_nhi;
                                r_mid <= w_nlo + ((w_nhi - w_nlo) >> 1);
                            end
                            default: r_phase <= PH_FIRST;
                        endcase
                    end
                end
                ST_DONE: begin
                    o_valid     <= 1'b1;
                    o_was_query <= r_cmd;
                    o_tile_min_x <= (r_cmd == CMD_QUERY) ? r_res[0] : 7'd0;
                    o_tile_min_y <= (r_cmd == CMD_QUERY) ? r_res[1] : 7'd0;
                    o_tile_max_x <= (r_cmd == CMD_QUERY) ? r_res[2] : 7'd0;
                    o_tile_max_y <= (r_cmd == CMD_QUERY) ? r_res[3] : 7'd0;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
